[rtl/sha384_hash_unit_assert.svh]
// ----------------------------------------------------------------------------
// SHA-384 hash unit assertion macros
// Concurrent checks clocked on i_clk, held off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SHA384_HASH_UNIT_ASSERT_SVH
`define SHA384_HASH_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define SHA384_ASSERT_IMPLY(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);
`define SHA384_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define SHA384_ASSERT_IMPLY(lbl, pre, post, msg)
`define SHA384_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

[rtl/shahu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-384 hash unit package
// Types, round constants and bit functions shared by the hash unit.
// ----------------------------------------------------------------------------
package shahu_pkg;

    typedef logic [63:0] t_word;

    localparam int SCHED_DEPTH = 16;
    localparam int WORD_BITS   = 64;
    localparam int LEN_BITS    = 64;

    typedef struct packed {
        logic        push_en;
        logic [3:0]  push_addr;
        t_word       push_data;
        logic [3:0]  rd_slot;
        logic        sched_en;
        logic [6:0]  sched_idx;
        logic        round_en;
        logic [6:0]  round_idx;
        logic        vars_load;
        logic        hash_add;
        logic        hash_init;
    } t_core_ctl;

    localparam t_word HASH_INIT [8] = '{
        64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17,
        64'h152fecd8f70e5939, 64'h67332667ffc00b31, 64'h8eb44a8768581511,
        64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4
    };

    function automatic t_word f_rotr(input t_word x, input int unsigned n);
        return (x >> n) | (x << (64 - n));
    endfunction

    function automatic t_word f_sig0(input t_word x);
        return f_rotr(x, 1) ^ f_rotr(x, 8) ^ (x >> 7);
    endfunction

    function automatic t_word f_sig1(input t_word x);
        return f_rotr(x, 19) ^ f_rotr(x, 61) ^ (x >> 6);
    endfunction

    function automatic t_word f_round_key(input logic [6:0] idx);
        t_word k;
        case (idx)
            7'd0:  k = 64'h428a2f98d728ae22;  7'd1:  k = 64'h7137449123ef65cd;
            7'd2:  k = 64'hb5c0fbcfec4d3b2f;  7'd3:  k = 64'he9b5dba58189dbbc;
            7'd4:  k = 64'h3956c25bf348b538;  7'd5:  k = 64'h59f111f1b605d019;
            7'd6:  k = 64'h923f82a4af194f9b;  7'd7:  k = 64'hab1c5ed5da6d8118;
            7'd8:  k = 64'hd807aa98a3030242;  7'd9:  k = 64'h12835b0145706fbe;
            7'd10: k = 64'h243185be4ee4b28c;  7'd11: k = 64'h550c7dc3d5ffb4e2;
            7'd12: k = 64'h72be5d74f27b896f;  7'd13: k = 64'h80deb1fe3b1696b1;
            7'd14: k = 64'h9bdc06a725c71235;  7'd15: k = 64'hc19bf174cf692694;
            7'd16: k = 64'he49b69c19ef14ad2;  7'd17: k = 64'hefbe4786384f25e3;
            7'd18: k = 64'h0fc19dc68b8cd5b5;  7'd19: k = 64'h240ca1cc77ac9c65;
            7'd20: k = 64'h2de92c6f592b0275;  7'd21: k = 64'h4a7484aa6ea6e483;
            7'd22: k = 64'h5cb0a9dcbd41fbd4;  7'd23: k = 64'h76f988da831153b5;
            7'd24: k = 64'h983e5152ee66dfab;  7'd25: k = 64'ha831c66d2db43210;
            7'd26: k = 64'hb00327c898fb213f;  7'd27: k = 64'hbf597fc7beef0ee4;
            7'd28: k = 64'hc6e00bf33da88fc2;  7'd29: k = 64'hd5a79147930aa725;
            7'd30: k = 64'h06ca6351e003826f;  7'd31: k = 64'h142929670a0e6e70;
            7'd32: k = 64'h27b70a8546d22ffc;  7'd33: k = 64'h2e1b21385c26c926;
            7'd34: k = 64'h4d2c6dfc5ac42aed;  7'd35: k = 64'h53380d139d95b3df;
            7'd36: k = 64'h650a73548baf63de;  7'd37: k = 64'h766a0abb3c77b2a8;
            7'd38: k = 64'h81c2c92e47edaee6;  7'd39: k = 64'h92722c851482353b;
            7'd40: k = 64'ha2bfe8a14cf10364;  7'd41: k = 64'ha81a664bbc423001;
            7'd42: k = 64'hc24b8b70d0f89791;  7'd43: k = 64'hc76c51a30654be30;
            7'd44: k = 64'hd192e819d6ef5218;  7'd45: k = 64'hd69906245565a910;
            7'd46: k = 64'hf40e35855771202a;  7'd47: k = 64'h106aa07032bbd1b8;
            7'd48: k = 64'h19a4c116b8d2d0c8;  7'd49: k = 64'h1e376c085141ab53;
            7'd50: k = 64'h2748774cdf8eeb99;  7'd51: k = 64'h34b0bcb5e19b48a8;
            7'd52: k = 64'h391c0cb3c5c95a63;  7'd53: k = 64'h4ed8aa4ae3418acb;
            7'd54: k = 64'h5b9cca4f7763e373;  7'd55: k = 64'h682e6ff3d6b2b8a3;
            7'd56: k = 64'h748f82ee5defb2fc;  7'd57: k = 64'h78a5636f43172f60;
            7'd58: k = 64'h84c87814a1f0ab72;  7'd59: k = 64'h8cc702081a6439ec;
            7'd60: k = 64'h90befffa23631e28;  7'd61: k = 64'ha4506cebde82bde9;
            7'd62: k = 64'hbef9a3f7b2c67915;  7'd63: k = 64'hc67178f2e372532b;
            7'd64: k = 64'hca273eceea26619c;  7'd65: k = 64'hd186b8c721c0c207;
            7'd66: k = 64'heada7dd6cde0eb1e;  7'd67: k = 64'hf57d4f7fee6ed178;
            7'd68: k = 64'h06f067aa72176fba;  7'd69: k = 64'h0a637dc5a2c898a6;
            7'd70: k = 64'h113f9804bef90dae;  7'd71: k = 64'h1b710b35131c471b;
            7'd72: k = 64'h28db77f523047d84;  7'd73: k = 64'h32caab7b40c72493;
            7'd74: k = 64'h3c9ebe0a15c9bebc;  7'd75: k = 64'h431d67c49c100d4c;
            7'd76: k = 64'h4cc5d4becb3e42b6;  7'd77: k = 64'h597f299cfc657e2a;
            7'd78: k = 64'h5fcb6fab3ad6faec;  7'd79: k = 64'h6c44198c4a475817;
            default: k = '0;
        endcase
        return k;
    endfunction

endpackage

[rtl/shahu_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module shahu_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_b,
    output logic [WIDTH-1:0]         o_rd_data_a,
    output logic [WIDTH-1:0]         o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data_a <= r_mem[i_rd_addr_a];
        o_rd_data_b <= r_mem[i_rd_addr_b];
    end

endmodule

[rtl/shahu_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-384 compression core
// Schedule memories, message schedule stage, round registers and hash words.
// ----------------------------------------------------------------------------
module shahu_core #(
    parameter int SCHED_DEPTH = shahu_pkg::SCHED_DEPTH,
    parameter int WORD_BITS   = shahu_pkg::WORD_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  shahu_pkg::t_core_ctl i_ctl,
    output shahu_pkg::t_word    o_hash [8]
);
    import shahu_pkg::*;

    t_word r_hash [8];
    t_word r_v    [8];
    t_word r_w;
    t_word w_ra0, w_ra1, w_rb0, w_rb1;
    t_word w_sched;
    t_word w_t1, w_t2;
    logic        w_wr_en;
    logic [3:0]  w_wr_addr;
    t_word       w_wr_data;

    // Two copies of the 16-word window give four reads per cycle:
    // A reads W[k-16], W[k-15]; B reads W[k-7], W[k-2].
    assign w_wr_en   = i_ctl.push_en | (i_ctl.sched_en & (i_ctl.sched_idx >= 7'd16));
    assign w_wr_addr = i_ctl.push_en ? i_ctl.push_addr : i_ctl.sched_idx[3:0];
    assign w_wr_data = i_ctl.push_en ? i_ctl.push_data : w_sched;

    shahu_ram #(.WIDTH(WORD_BITS), .DEPTH(SCHED_DEPTH)) u_ram_a (
        .i_clk       (i_clk),
        .i_wr_en     (w_wr_en),
        .i_wr_addr   (w_wr_addr),
        .i_wr_data   (w_wr_data),
        .i_rd_addr_a (i_ctl.rd_slot),
        .i_rd_addr_b (i_ctl.rd_slot + 4'd1),
        .o_rd_data_a (w_ra0),
        .o_rd_data_b (w_ra1)
    );

    shahu_ram #(.WIDTH(WORD_BITS), .DEPTH(SCHED_DEPTH)) u_ram_b (
        .i_clk       (i_clk),
        .i_wr_en     (w_wr_en),
        .i_wr_addr   (w_wr_addr),
        .i_wr_data   (w_wr_data),
        .i_rd_addr_a (i_ctl.rd_slot + 4'd9),
        .i_rd_addr_b (i_ctl.rd_slot + 4'd14),
        .o_rd_data_a (w_rb0),
        .o_rd_data_b (w_rb1)
    );

    assign w_sched = (i_ctl.sched_idx < 7'd16) ? w_ra0
                   : f_sig1(w_rb1) + w_rb0 + f_sig0(w_ra1) + w_ra0;

    assign w_t1 = r_v[7] + (f_rotr(r_v[4], 14) ^ f_rotr(r_v[4], 18) ^ f_rotr(r_v[4], 41))
                + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
                + f_round_key(i_ctl.round_idx) + r_w;
    assign w_t2 = (f_rotr(r_v[0], 28) ^ f_rotr(r_v[0], 34) ^ f_rotr(r_v[0], 39))
                + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));

    always_ff @(posedge i_clk) begin
        if (i_ctl.sched_en) begin
            r_w <= w_sched;
        end
        if (i_ctl.vars_load) begin
            r_v <= r_hash;
        end else if (i_ctl.round_en) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + w_t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= w_t1 + w_t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.hash_init) begin
            r_hash <= HASH_INIT;
        end else if (i_ctl.hash_add) begin
            for (int i = 0; i < 8; i++) begin
                r_hash[i] <= r_hash[i] + r_v[i];
            end
        end
    end

    assign o_hash = r_hash;

endmodule

[rtl/sha384_hash_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-384 hash unit
// Streams 64-bit big-endian message words, pads on the final word and
// returns the 384-bit digest as six 64-bit words.
// ----------------------------------------------------------------------------
// Usage: message words are loaded one per cycle, while o_in_stall is low,
// into the 16-word schedule memory. The 16th word of a block starts a
// compression pass (read prefetch, a schedule stage, 80 rounds behind it,
// then the hash update) while the input is stalled. The message rate is
// set by the single round unit doing one SHA-512 round per cycle. On the
// final word the unit writes the pad and length words itself, one per cycle,
// spending one or two extra compression passes, then presents the six
// digest words, index 0 first, and starts over from the initial hash.
// ----------------------------------------------------------------------------
`include "sha384_hash_unit_assert.svh"

module sha384_hash_unit #(
    parameter int LENGTH_COUNTER_BITS = shahu_pkg::LEN_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request input
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  shahu_pkg::t_word   i_data_word,
    input  logic [3:0]         i_valid_bytes,
    input  logic               i_final_word,
    // digest output
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output shahu_pkg::t_word   o_digest_word,
    output logic [2:0]         o_word_index,
    output logic               o_last_digest_word
);
    import shahu_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_HASH,
        ST_ADD,
        ST_OUT
    } t_state;

    // Mask for the 128-bit length field: bit count modulo 2^LENGTH_COUNTER_BITS.
    localparam logic [127:0] LEN_MASK = (LENGTH_COUNTER_BITS >= 128) ? {128{1'b1}}
        : ((128'(1) << LENGTH_COUNTER_BITS) - 128'(1));
    localparam t_word PAD_WORD = 64'h8000_0000_0000_0000;

    t_state      r_state;
    logic [3:0]  r_wib;       // words in open block
    logic [63:0] r_bytes;     // message bytes, wraps
    logic [6:0]  r_cnt;       // pass cycle / output word index
    logic        r_final;     // padding phase
    logic        r_need80;    // next pad word is the 0x80 word
    logic        r_hi_done;
    logic        r_lo_done;
    logic        r_out_valid;
    t_word       r_out_word;
    logic [2:0]  r_out_idx;
    logic        r_out_last;

    t_core_ctl   w_ctl;
    t_word       w_hash [8];
    logic        w_in_acc;
    logic [3:0]  w_nv;
    t_word       w_in_word;
    t_word       w_pad_word;
    logic [127:0] w_len;

    assign w_in_acc = i_in_valid && !o_in_stall;
    assign w_nv     = (i_valid_bytes > 4'd8) ? 4'd8 : i_valid_bytes;
    assign w_len    = {61'b0, r_bytes, 3'b000} & LEN_MASK;

    // Final short word: keep the valid top bytes and place the 0x80 pad
    // right below them. A full final word is pushed as is.
    always_comb begin
        if (!i_final_word || w_nv == 4'd8) begin
            w_in_word = i_data_word;
        end else begin
            w_in_word = (i_data_word & ~({64{1'b1}} >> {w_nv, 3'b000}))
                      | (PAD_WORD >> {w_nv, 3'b000});
        end
    end

    // Word order in padding: 0x80 word, zero fill to slot 14, length hi, lo.
    always_comb begin
        if (r_need80) begin
            w_pad_word = PAD_WORD;
        end else if (r_hi_done) begin
            w_pad_word = w_len[63:0];
        end else if (r_wib != 4'd14) begin
            w_pad_word = '0;
        end else begin
            w_pad_word = w_len[127:64];
        end
    end

    always_comb begin
        w_ctl           = '0;
        w_ctl.push_addr = r_wib;
        w_ctl.rd_slot   = r_cnt[3:0];
        w_ctl.sched_idx = r_cnt - 7'd1;
        w_ctl.round_idx = r_cnt - 7'd2;
        case (r_state)
            ST_IDLE: begin
                w_ctl.push_en   = w_in_acc;
                w_ctl.push_data = w_in_word;
            end
            ST_PAD: begin
                w_ctl.push_en   = 1'b1;
                w_ctl.push_data = w_pad_word;
            end
            ST_HASH: begin
                w_ctl.vars_load = (r_cnt == 7'd0);
                w_ctl.sched_en  = (r_cnt >= 7'd1) && (r_cnt <= 7'd80);
                w_ctl.round_en  = (r_cnt >= 7'd2);
            end
            ST_ADD: begin
                w_ctl.hash_add = 1'b1;
            end
            ST_OUT: begin
                w_ctl.hash_init = (r_cnt == 7'd6) && r_out_valid && !i_out_stall;
            end
            default: begin
                w_ctl = '0;
            end
        endcase
    end

    shahu_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .o_hash  (w_hash)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wib       <= '0;
            r_bytes     <= '0;
            r_cnt       <= '0;
            r_final     <= 1'b0;
            r_need80    <= 1'b0;
            r_hi_done   <= 1'b0;
            r_lo_done   <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_last  <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_wib   <= r_wib + 4'd1;
                        r_bytes <= r_bytes + (i_final_word ? 64'(w_nv) : 64'd8);
                        r_cnt   <= '0;
                        if (i_final_word) begin
                            r_final   <= 1'b1;
                            r_need80  <= (w_nv == 4'd8);
                            r_hi_done <= 1'b0;
                            r_lo_done <= 1'b0;
                        end
                        if (r_wib == 4'd15) begin
                            r_state <= ST_HASH;
                        end else if (i_final_word) begin
                            r_state <= ST_PAD;
                        end
                    end
                end
                ST_PAD: begin
                    r_wib <= r_wib + 4'd1;
                    r_cnt <= '0;
                    if (r_need80) begin
                        r_need80 <= 1'b0;
                    end else if (r_hi_done) begin
                        r_lo_done <= 1'b1;
                    end else if (r_wib == 4'd14) begin
                        r_hi_done <= 1'b1;
                    end
                    if (r_wib == 4'd15) begin
                        r_state <= ST_HASH;
                    end
                end
                ST_HASH: begin
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt == 7'd81) begin
                        r_state <= ST_ADD;
                    end
                end
                ST_ADD: begin
                    r_cnt <= '0;
                    if (r_lo_done) begin
                        r_state <= ST_OUT;
                    end else if (r_final) begin
                        r_state <= ST_PAD;
                    end else begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        if (r_cnt == 7'd6) begin
                            r_out_valid <= 1'b0;
                            r_out_last  <= 1'b0;
                            r_final     <= 1'b0;
                            r_lo_done   <= 1'b0;
                            r_hi_done   <= 1'b0;
                            r_bytes     <= '0;
                            r_cnt       <= '0;
                            r_state     <= ST_IDLE;
                        end else begin
                            r_out_valid <= 1'b1;
                            r_out_word  <= w_hash[r_cnt[2:0]];
                            r_out_idx   <= r_cnt[2:0];
                            r_out_last  <= (r_cnt == 7'd5);
                            r_cnt       <= r_cnt + 7'd1;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall         = (r_state != ST_IDLE);
    assign o_out_valid        = r_out_valid;
    assign o_digest_word      = r_out_word;
    assign o_word_index       = r_out_idx;
    assign o_last_digest_word = r_out_last;

    // A compression pass or digest readout only runs on a full block.
    `SHA384_ASSERT_IMPLY(a_block_full, (r_state == ST_HASH || r_state == ST_ADD || r_state == ST_OUT), (r_wib == 4'd0), "pass without a full block")
    // Digest words only appear in the readout state.
    `SHA384_ASSERT_IMPLY(a_out_state, r_out_valid, (r_state == ST_OUT), "digest valid outside readout")
    // The last digest word carries index five.
    `SHA384_ASSERT_IMPLY(a_last_idx, (r_out_valid && r_out_last), (r_out_idx == 3'd5), "last word index")
    // Taking the last digest word returns the unit to idle.
    `SHA384_ASSERT_NEXT(a_back_idle, (r_out_valid && r_out_last && !i_out_stall), (r_state == ST_IDLE && !r_final), "no restart after digest")

endmodule
